FILE: hdl/plbu_pkg.sv
// Shared types and codes of the price level book update core.
// Depends on nothing; imported by the core.
package plbu_pkg;

  typedef enum logic [1:0] {
    OP_SNAP   = 2'd0,
    OP_CHANGE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_PRICE   = 3'd1,
    ST_QTY     = 3'd2,
    ST_DUP     = 3'd3,
    ST_MISSING = 3'd4,
    ST_CROSSED = 3'd5,
    ST_FULL    = 3'd6,
    ST_LONG    = 3'd7
  } status_t;

  localparam int PriceW = 32;
  localparam int LevelW = 31;
  localparam int TotalW = 37;

  function automatic logic value_bad(input logic [PriceW-1:0] v);
    return (v == '0) || v[PriceW-1];
  endfunction

endpackage

FILE: hdl/plbu_ram.sv
// Generic single write port, single registered read port RAM.
// Depends on nothing.
module plbu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/price_level_book_update_core.sv
// Price level book: one bid and one ask table kept in a banked RAM, updated a batch at a time.
// Depends on plbu_pkg and plbu_ram.
//
// A batch beat without last is stored and the input stays ready. A beat that closes a batch
// of n items, a clear and a query each hold the input off until the sequencer is done; every
// RAM access is a read state followed by a state that uses the data, because both memories
// have one registered read port. The final summary scan reads every slot of both sides. A
// closing beat first checks its items (pairwise duplicate search over the batch buffer), for a
// change searches the live bank per removal and copies the live bank into the spare bank, then
// searches the spare bank per item to apply it and scans it for the crossed check. A new beat
// is taken while the previous result still waits at the output.
module price_level_book_update_core
  import plbu_pkg::*;
#(
  parameter int BOOK_DEPTH = 64,
  parameter int MAX_BATCH  = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // price[31:0], quantity[63:32]
  input  logic [2:0]   in_tuser,   // opcode[1:0], side[2]
  input  logic         in_tlast,   // last
  output logic         out_tvalid,
  input  logic         out_tready,
  // bid_valid[0], bid_price[31:1], bid_quantity[62:32], ask_valid[63], ask_price[94:64],
  // ask_quantity[125:95], bid_total[162:126], ask_total[199:163]
  output logic [199:0] out_tdata,
  output logic [2:0]   out_tuser   // status[2:0]
);

  localparam int SA_W   = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
  localparam int SC_W   = $clog2(BOOK_DEPTH + 1);
  localparam int PA_W   = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
  localparam int CNT_W  = $clog2(MAX_BATCH + 1);
  localparam int BK_DEP = 4 << SA_W;
  localparam int BK_AW  = SA_W + 2;
  localparam int PD_W   = 1 + 2 * PriceW;
  localparam int BK_W   = 2 * LevelW;

  typedef enum logic [16:0] {
    S_IDLE    = 17'h00001,
    S_RUN     = 17'h00002,
    S_CHK_RD  = 17'h00004,
    S_CHK_I   = 17'h00008,
    S_DUP_RD  = 17'h00010,
    S_DUP_EV  = 17'h00020,
    S_FND_RD  = 17'h00040,
    S_FND_EV  = 17'h00080,
    S_COPY_RD = 17'h00100,
    S_COPY_WR = 17'h00200,
    S_APP_RD  = 17'h00400,
    S_APP_LD  = 17'h00800,
    S_SRCH_RD = 17'h01000,
    S_SRCH_EV = 17'h02000,
    S_SCAN_RD = 17'h04000,
    S_SCAN_EV = 17'h08000,
    S_EMIT    = 17'h10000
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic upd_r, upd_nxt, ovf_r, ovf_nxt, act_r, act_nxt;
  logic [BOOK_DEPTH-1:0] used_r [2][2];
  logic [BOOK_DEPTH-1:0] used_nxt [2][2];
  logic out_valid_r, out_valid_nxt;

  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic pass_r, pass_nxt;
  logic [SC_W-1:0] k_r, k_nxt;
  logic ks_r, ks_nxt, xmode_r, xmode_nxt, bank_r, bank_nxt;
  status_t st_r, st_nxt, fin_st;
  logic pi_side_r, pi_side_nxt;
  logic [PriceW-1:0] pi_price_r, pi_price_nxt, pi_qty_r, pi_qty_nxt;
  logic free_ok_r, free_ok_nxt;
  logic [SA_W-1:0] free_slot_r, free_slot_nxt;
  logic bb_v_r, bb_v_nxt, ba_v_r, ba_v_nxt;
  logic [LevelW-1:0] bb_p_r, bb_p_nxt, bb_q_r, bb_q_nxt, ba_p_r, ba_p_nxt, ba_q_r, ba_q_nxt;
  logic [TotalW-1:0] bt_r, bt_nxt, at_r, at_nxt, sum_in, sum_out;
  logic out_load;
  logic [199:0] out_data_r;
  status_t out_st_r;

  logic do_scan, do_fin, scan_cand, cand;
  logic [SA_W-1:0] kslot;
  op_t in_op;

  logic pd_we;
  logic [PA_W-1:0] pd_waddr, pd_raddr;
  logic [PD_W-1:0] pd_wdata, pd_rdata;
  logic pd_side;
  logic [PriceW-1:0] pd_price, pd_qty;

  logic bk_we;
  logic [BK_AW-1:0] bk_waddr, bk_raddr;
  logic [BK_W-1:0] bk_wdata, bk_rdata;
  logic [LevelW-1:0] bk_price, bk_qty;

  plbu_ram #(.WIDTH(PD_W), .DEPTH(MAX_BATCH)) u_pend_ram (
    .clk(clk), .we(pd_we), .waddr(pd_waddr), .wdata(pd_wdata),
    .raddr(pd_raddr), .rdata(pd_rdata)
  );

  plbu_ram #(.WIDTH(BK_W), .DEPTH(BK_DEP)) u_book_ram (
    .clk(clk), .we(bk_we), .waddr(bk_waddr), .wdata(bk_wdata),
    .raddr(bk_raddr), .rdata(bk_rdata)
  );

  assign in_op    = op_t'(in_tuser[1:0]);
  assign pd_side  = pd_rdata[PD_W-1];
  assign pd_price = pd_rdata[2*PriceW-1:PriceW];
  assign pd_qty   = pd_rdata[PriceW-1:0];
  assign bk_price = bk_rdata[BK_W-1:LevelW];
  assign bk_qty   = bk_rdata[LevelW-1:0];
  assign kslot    = k_r[SA_W-1:0];
  assign cand     = ~act_r;
  assign sum_out  = sum_in + TotalW'(bk_qty);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_st_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    upd_nxt       = upd_r;
    ovf_nxt       = ovf_r;
    act_nxt       = act_r;
    used_nxt      = used_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    i_nxt         = i_r;
    j_nxt         = j_r;
    pass_nxt      = pass_r;
    k_nxt         = k_r;
    ks_nxt        = ks_r;
    xmode_nxt     = xmode_r;
    bank_nxt      = bank_r;
    st_nxt        = st_r;
    pi_side_nxt   = pi_side_r;
    pi_price_nxt  = pi_price_r;
    pi_qty_nxt    = pi_qty_r;
    free_ok_nxt   = free_ok_r;
    free_slot_nxt = free_slot_r;
    bb_v_nxt      = bb_v_r;
    bb_p_nxt      = bb_p_r;
    bb_q_nxt      = bb_q_r;
    ba_v_nxt      = ba_v_r;
    ba_p_nxt      = ba_p_r;
    ba_q_nxt      = ba_q_r;
    bt_nxt        = bt_r;
    at_nxt        = at_r;
    sum_in        = ks_r ? at_r : bt_r;
    out_load      = 1'b0;
    do_scan       = 1'b0;
    do_fin        = 1'b0;
    scan_cand     = 1'b0;
    fin_st        = ST_OK;
    pd_we         = 1'b0;
    pd_waddr      = cnt_r[PA_W-1:0];
    pd_wdata      = {in_tuser[2], in_tdata[31:0], in_tdata[63:32]};
    pd_raddr      = i_r[PA_W-1:0];
    bk_we         = 1'b0;
    bk_waddr      = '0;
    bk_wdata      = '0;
    bk_raddr      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          unique case (in_op) inside
            OP_QUERY: begin
              do_scan = 1'b1;
              st_nxt  = ST_OK;
            end
            OP_CLEAR: begin
              for (int s = 0; s < 2; s++) begin
                for (int b = 0; b < 2; b++) begin
                  used_nxt[s][b] = '0;
                end
              end
              do_fin = 1'b1;
            end
            OP_SNAP, OP_CHANGE: begin
              if (cnt_r == '0 && !ovf_r) begin
                upd_nxt = (in_op == OP_CHANGE);
              end
              if (cnt_r < CNT_W'(MAX_BATCH)) begin
                pd_we   = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
              if (in_tlast) begin
                state_nxt = S_RUN;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_RUN: begin
        if (ovf_r) begin
          do_fin = 1'b1;
          fin_st = ST_LONG;
        end else begin
          i_nxt     = '0;
          pass_nxt  = 1'b0;
          state_nxt = S_CHK_RD;
        end
      end
      S_CHK_RD: begin
        if (i_r == cnt_r) begin
          if (upd_r) begin
            for (int s = 0; s < 2; s++) begin
              used_nxt[s][cand] = used_r[s][act_r];
            end
            k_nxt     = '0;
            ks_nxt    = 1'b0;
            state_nxt = S_COPY_RD;
          end else if (!pass_r) begin
            pass_nxt = 1'b1;
            i_nxt    = '0;
          end else begin
            for (int s = 0; s < 2; s++) begin
              used_nxt[s][cand] = '0;
            end
            i_nxt     = '0;
            state_nxt = S_APP_RD;
          end
        end else begin
          state_nxt = S_CHK_I;
        end
      end
      S_CHK_I: begin
        pi_side_nxt  = pd_side;
        pi_price_nxt = pd_price;
        pi_qty_nxt   = pd_qty;
        j_nxt        = '0;
        if (!upd_r && pd_side != pass_r) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_CHK_RD;
        end else if (value_bad(pd_price)) begin
          do_fin = 1'b1;
          fin_st = ST_PRICE;
        end else if (upd_r ? pd_qty[PriceW-1] : value_bad(pd_qty)) begin
          do_fin = 1'b1;
          fin_st = ST_QTY;
        end else begin
          state_nxt = S_DUP_RD;
        end
      end
      S_DUP_RD: begin
        if (j_r == i_r) begin
          if (upd_r && pi_qty_r == '0) begin
            k_nxt     = '0;
            state_nxt = S_FND_RD;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_CHK_RD;
          end
        end else begin
          pd_raddr  = j_r[PA_W-1:0];
          state_nxt = S_DUP_EV;
        end
      end
      S_DUP_EV: begin
        if (pd_side == pi_side_r && pd_price == pi_price_r) begin
          do_fin = 1'b1;
          fin_st = ST_DUP;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_DUP_RD;
        end
      end
      S_FND_RD: begin
        if (k_r == SC_W'(BOOK_DEPTH)) begin
          do_fin = 1'b1;
          fin_st = ST_MISSING;
        end else begin
          bk_raddr  = {pi_side_r, act_r, kslot};
          state_nxt = S_FND_EV;
        end
      end
      S_FND_EV: begin
        if (used_r[pi_side_r][act_r][kslot] && bk_price == pi_price_r[LevelW-1:0]) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_CHK_RD;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_FND_RD;
        end
      end
      S_COPY_RD: begin
        if (k_r == SC_W'(BOOK_DEPTH)) begin
          if (ks_r) begin
            i_nxt     = '0;
            state_nxt = S_APP_RD;
          end else begin
            ks_nxt = 1'b1;
            k_nxt  = '0;
          end
        end else begin
          bk_raddr  = {ks_r, act_r, kslot};
          state_nxt = S_COPY_WR;
        end
      end
      S_COPY_WR: begin
        bk_we     = 1'b1;
        bk_waddr  = {ks_r, cand, kslot};
        bk_wdata  = bk_rdata;
        k_nxt     = k_r + 1'b1;
        state_nxt = S_COPY_RD;
      end
      S_APP_RD: begin
        if (i_r == cnt_r) begin
          do_scan   = 1'b1;
          scan_cand = 1'b1;
        end else begin
          state_nxt = S_APP_LD;
        end
      end
      S_APP_LD: begin
        pi_side_nxt  = pd_side;
        pi_price_nxt = pd_price;
        pi_qty_nxt   = pd_qty;
        k_nxt        = '0;
        free_ok_nxt  = 1'b0;
        state_nxt    = S_SRCH_RD;
      end
      S_SRCH_RD: begin
        if (k_r == SC_W'(BOOK_DEPTH)) begin
          if (pi_qty_r == '0) begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_APP_RD;
          end else if (free_ok_r) begin
            bk_we     = 1'b1;
            bk_waddr  = {pi_side_r, cand, free_slot_r};
            bk_wdata  = {pi_price_r[LevelW-1:0], pi_qty_r[LevelW-1:0]};
            used_nxt[pi_side_r][cand][free_slot_r] = 1'b1;
            i_nxt     = i_r + 1'b1;
            state_nxt = S_APP_RD;
          end else begin
            do_fin = 1'b1;
            fin_st = ST_FULL;
          end
        end else begin
          bk_raddr  = {pi_side_r, cand, kslot};
          state_nxt = S_SRCH_EV;
        end
      end
      S_SRCH_EV: begin
        if (used_r[pi_side_r][cand][kslot] && bk_price == pi_price_r[LevelW-1:0]) begin
          if (pi_qty_r == '0) begin
            used_nxt[pi_side_r][cand][kslot] = 1'b0;
          end else begin
            bk_we    = 1'b1;
            bk_waddr = {pi_side_r, cand, kslot};
            bk_wdata = {pi_price_r[LevelW-1:0], pi_qty_r[LevelW-1:0]};
          end
          i_nxt     = i_r + 1'b1;
          state_nxt = S_APP_RD;
        end else begin
          if (!used_r[pi_side_r][cand][kslot] && !free_ok_r) begin
            free_ok_nxt   = 1'b1;
            free_slot_nxt = kslot;
          end
          k_nxt     = k_r + 1'b1;
          state_nxt = S_SRCH_RD;
        end
      end
      S_SCAN_RD: begin
        if (k_r == SC_W'(BOOK_DEPTH)) begin
          if (ks_r) begin
            if (xmode_r) begin
              do_fin = 1'b1;
              if (bb_v_r && ba_v_r && bb_p_r >= ba_p_r) begin
                fin_st = ST_CROSSED;
              end else begin
                act_nxt = cand;
              end
            end else begin
              state_nxt = S_EMIT;
            end
          end else begin
            ks_nxt = 1'b1;
            k_nxt  = '0;
          end
        end else begin
          bk_raddr  = {ks_r, bank_r, kslot};
          state_nxt = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        if (used_r[ks_r][bank_r][kslot]) begin
          if (ks_r) begin
            at_nxt = sum_out;
            if (!ba_v_r || bk_price < ba_p_r) begin
              ba_v_nxt = 1'b1;
              ba_p_nxt = bk_price;
              ba_q_nxt = bk_qty;
            end
          end else begin
            bt_nxt = sum_out;
            if (!bb_v_r || bk_price > bb_p_r) begin
              bb_v_nxt = 1'b1;
              bb_p_nxt = bk_price;
              bb_q_nxt = bk_qty;
            end
          end
        end
        k_nxt     = k_r + 1'b1;
        state_nxt = S_SCAN_RD;
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (do_fin) begin
      do_scan = 1'b1;
      st_nxt  = fin_st;
      cnt_nxt = '0;
      upd_nxt = 1'b0;
      ovf_nxt = 1'b0;
    end
    if (do_scan) begin
      k_nxt     = '0;
      ks_nxt    = 1'b0;
      bb_v_nxt  = 1'b0;
      bb_p_nxt  = '0;
      bb_q_nxt  = '0;
      ba_v_nxt  = 1'b0;
      ba_p_nxt  = '0;
      ba_q_nxt  = '0;
      bt_nxt    = '0;
      at_nxt    = '0;
      xmode_nxt = scan_cand;
      bank_nxt  = scan_cand ? cand : act_nxt;
      state_nxt = S_SCAN_RD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      upd_r       <= 1'b0;
      ovf_r       <= 1'b0;
      act_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int s = 0; s < 2; s++) begin
        for (int b = 0; b < 2; b++) begin
          used_r[s][b] <= '0;
        end
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      upd_r       <= upd_nxt;
      ovf_r       <= ovf_nxt;
      act_r       <= act_nxt;
      out_valid_r <= out_valid_nxt;
      used_r      <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    pass_r      <= pass_nxt;
    k_r         <= k_nxt;
    ks_r        <= ks_nxt;
    xmode_r     <= xmode_nxt;
    bank_r      <= bank_nxt;
    st_r        <= st_nxt;
    pi_side_r   <= pi_side_nxt;
    pi_price_r  <= pi_price_nxt;
    pi_qty_r    <= pi_qty_nxt;
    free_ok_r   <= free_ok_nxt;
    free_slot_r <= free_slot_nxt;
    bb_v_r      <= bb_v_nxt;
    bb_p_r      <= bb_p_nxt;
    bb_q_r      <= bb_q_nxt;
    ba_v_r      <= ba_v_nxt;
    ba_p_r      <= ba_p_nxt;
    ba_q_r      <= ba_q_nxt;
    bt_r        <= bt_nxt;
    at_r        <= at_nxt;
    if (out_load) begin
      out_st_r   <= st_r;
      out_data_r <= {at_r, bt_r, ba_q_r, ba_p_r, ba_v_r, bb_q_r, bb_p_r, bb_v_r};
    end
  end

endmodule

FILE: hdl/plbu_checker.sv
// Port-level checks of the price level book update core and their bind.
// Depends only on the top level's ports.
module plbu_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [199:0] out_tdata,
  input logic [2:0]   out_tuser
);

  // An empty bid side reports a zero price and quantity.
  a_bid_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[62:1] == '0)
    else $error("empty bid side with nonzero level");

  // An empty ask side reports a zero price and quantity.
  a_ask_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[63] |-> out_tdata[125:64] == '0)
    else $error("empty ask side with nonzero level");

  // The committed book is never locked or crossed.
  a_not_crossed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] && out_tdata[63] |-> out_tdata[31:1] < out_tdata[94:64])
    else $error("book reported locked or crossed");

  // A result beat that waits stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("waiting result beat changed or dropped");

  // No result beat is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat offered after reset");

endmodule

bind price_level_book_update_core plbu_checker u_plbu_checker (.*);
